@@ rtl/core/sfs_pkg.sv @@
// shared types, constants and helper functions for the slot allocator
// no dependencies; used by sfs_ctrl, sfs_datapath and the top level

package sfs_pkg;

  // slot space
  localparam int MAX_SLOTS  = 4096;
  localparam int BASE_SLOTS = 32;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS) + 1;
  localparam int LEVEL_W    = 3;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GROW  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_SLOT     = 2'd1,
    ST_BAD_FREE    = 2'd2,
    ST_CANNOT_GROW = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request and start memory reads
    logic exec;     // apply the request and load the result register
  } ctrl_cmd_t;

  // capacity after reset or a level write, saturated at the slot space
  function automatic logic [CNT_W-1:0] init_capacity(input logic [LEVEL_W-1:0] lvl);
    logic [CNT_W+7:0] c;
    c = (CNT_W+8)'(BASE_SLOTS) << lvl;
    if (c > (CNT_W+8)'(MAX_SLOTS)) begin
      c = (CNT_W+8)'(MAX_SLOTS);
    end
    return c[CNT_W-1:0];
  endfunction

endpackage

@@ rtl/core/sfs_ctrl.sv @@
// request sequencer for the slot allocator: idle / execute state machine
// and the result valid flag; depends on sfs_pkg

module sfs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sfs_pkg::ctrl_cmd_t cmd
);

  sfs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // result register can take a new item
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfs_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sfs_pkg::S_EXEC;
      end
      sfs_pkg::S_EXEC: begin
        if (out_free) state_nxt = sfs_pkg::S_IDLE;
      end
      default: state_nxt = sfs_pkg::S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      sfs_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      sfs_pkg::S_EXEC: begin
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture is always followed by execute
  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == sfs_pkg::S_EXEC)
    else $error("capture not followed by execute state");

  // executing fills the result register
  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("result not valid after execute");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.exec)
    else $error("execute while result register is stalled");

endmodule

@@ rtl/core/sfs_datapath.sv @@
// datapath of the slot allocator: free stack and occupancy memories,
// counters, capacity and the result register; depends on sfs_pkg

module sfs_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfs_pkg::ctrl_cmd_t             cmd,
  input  logic [sfs_pkg::OP_W-1:0]       in_op,
  input  logic [sfs_pkg::SLOT_W-1:0]     in_freed_index,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::LEVEL_W-1:0]    cfg_start_level,
  output logic [sfs_pkg::SLOT_W-1:0]     out_given_index,
  output logic [sfs_pkg::STATUS_W-1:0]   out_status
);

  localparam int SW = sfs_pkg::SLOT_W;
  localparam int CW = sfs_pkg::CNT_W;

  // memories; occupancy entries at or above the high-water mark read as free
  logic [SW-1:0] stack_mem [sfs_pkg::MAX_SLOTS];
  logic          occ_mem   [sfs_pkg::MAX_SLOTS];

  // request registers and registered read data
  sfs_pkg::op_t  op_r;
  logic [SW-1:0] idx_r;
  logic [SW-1:0] stack_rd_r;
  logic          occ_rd_r;

  // allocator state
  logic [CW-1:0] stack_count_r, stack_count_nxt;
  logic [CW-1:0] high_water_r, high_water_nxt;
  logic [CW-1:0] capacity_r, capacity_nxt;

  // result register
  logic [SW-1:0]      out_given_r, given_nxt;
  sfs_pkg::status_t   out_status_r, status_nxt;

  // memory write controls
  logic          occ_we;
  logic [SW-1:0] occ_waddr;
  logic          occ_wdata;
  logic          stack_we;
  logic [SW-1:0] stack_rd_addr;
  logic          occ_valid;
  logic [CW:0]   cap_dbl;

  assign stack_rd_addr = SW'(stack_count_r - CW'(1));
  assign occ_valid     = ({1'b0, idx_r} < high_water_r) && occ_rd_r;
  assign cap_dbl       = {capacity_r, 1'b0};

  // request evaluation
  always_comb begin
    given_nxt       = '0;
    status_nxt      = sfs_pkg::ST_OK;
    stack_count_nxt = stack_count_r;
    high_water_nxt  = high_water_r;
    capacity_nxt    = capacity_r;
    occ_we          = 1'b0;
    occ_waddr       = idx_r;
    occ_wdata       = 1'b0;
    stack_we        = 1'b0;
    unique case (op_r)
      sfs_pkg::OP_ALLOC: begin
        if (stack_count_r != '0) begin
          // reuse the most recently freed slot
          stack_count_nxt = stack_count_r - CW'(1);
          given_nxt       = stack_rd_r;
          occ_we          = 1'b1;
          occ_waddr       = stack_rd_r;
          occ_wdata       = 1'b1;
        end else if (high_water_r >= capacity_r ||
                     high_water_r >= CW'(sfs_pkg::MAX_SLOTS)) begin
          status_nxt = sfs_pkg::ST_NO_SLOT;
        end else begin
          // fresh slot from the high-water mark
          given_nxt      = high_water_r[SW-1:0];
          occ_we         = 1'b1;
          occ_waddr      = high_water_r[SW-1:0];
          occ_wdata      = 1'b1;
          high_water_nxt = high_water_r + CW'(1);
        end
      end
      sfs_pkg::OP_FREE: begin
        if ({1'b0, idx_r} >= capacity_r || !occ_valid ||
            stack_count_r >= CW'(sfs_pkg::MAX_SLOTS)) begin
          status_nxt = sfs_pkg::ST_BAD_FREE;
        end else begin
          occ_we          = 1'b1;
          occ_wdata       = 1'b0;
          stack_we        = 1'b1;
          stack_count_nxt = stack_count_r + CW'(1);
        end
      end
      sfs_pkg::OP_GROW: begin
        if (capacity_r >= CW'(sfs_pkg::MAX_SLOTS)) begin
          status_nxt = sfs_pkg::ST_CANNOT_GROW;
        end else if (cap_dbl > (CW+1)'(sfs_pkg::MAX_SLOTS)) begin
          capacity_nxt = CW'(sfs_pkg::MAX_SLOTS);
        end else begin
          capacity_nxt = cap_dbl[CW-1:0];
        end
      end
      sfs_pkg::OP_NOP: ;
      default: ;
    endcase
  end

  // request capture and memory reads
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= sfs_pkg::op_t'(in_op);
      idx_r      <= in_freed_index;
      stack_rd_r <= stack_mem[stack_rd_addr];
      occ_rd_r   <= occ_mem[in_freed_index];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.exec && stack_we) begin
      stack_mem[stack_count_r[SW-1:0]] <= idx_r;
    end
    if (cmd.exec && occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
  end

  // allocator state; a level write reloads the capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r <= '0;
      high_water_r  <= '0;
      capacity_r    <= sfs_pkg::init_capacity('0);
    end else begin
      if (cmd.exec) begin
        stack_count_r <= stack_count_nxt;
        high_water_r  <= high_water_nxt;
      end
      if (cfg_we) begin
        capacity_r <= sfs_pkg::init_capacity(cfg_start_level);
      end else if (cmd.exec) begin
        capacity_r <= capacity_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_given_r  <= given_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_given_index = out_given_r;
  assign out_status      = out_status_r;

  // stack never holds more than the slot space
  a_stack_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    stack_count_r <= CW'(sfs_pkg::MAX_SLOTS))
    else $error("free stack count out of range");

  // capacity stays within base and maximum
  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    capacity_r >= CW'(sfs_pkg::BASE_SLOTS) && capacity_r <= CW'(sfs_pkg::MAX_SLOTS))
    else $error("capacity out of range");

  // an accepted free pushes exactly one entry
  a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == sfs_pkg::OP_FREE && status_nxt == sfs_pkg::ST_OK)
      |=> stack_count_r == $past(stack_count_r) + CW'(1))
    else $error("free did not push onto the stack");

  // a slot taken from the stack was below the high-water mark
  a_pop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == sfs_pkg::OP_ALLOC && stack_count_r != '0)
      |-> {1'b0, stack_rd_r} < high_water_r)
    else $error("stack entry above high-water mark");

endmodule

@@ rtl/core/slot_allocator_free_stack_top.sv @@
// Slot allocator with a LIFO free stack and a high-water mark.
//
// Channels: in_valid/in_ready carry a request (in_op: allocate, free,
// grow; in_freed_index for free). out_valid/out_ready return one item per
// request with out_given_index and out_status. cfg_valid/cfg_ready write
// start_level, which reloads the capacity to 32 << level (max 4096);
// cfg_ready is always high and writes are meant for an idle block.
//
// Timing: each request is a read-modify-write of the stack and occupancy
// memories: read at accept in the idle state, written in the execute state.
// The result register loads when execute completes; a new request is taken
// only once the block is back in idle, so requests never overlap.
//
// Reset: counters clear and capacity returns to 32. No clearing pass is
// needed; occupancy at or above the high-water mark is treated as free.
// Receiver stall: the result waits in its register and the block holds the
// next accepted request until the register frees up.
// Depends on sfs_pkg, sfs_ctrl and sfs_datapath.

module slot_allocator_free_stack_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfs_pkg::OP_W-1:0]       in_op,
  input  logic [sfs_pkg::SLOT_W-1:0]     in_freed_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfs_pkg::SLOT_W-1:0]     out_given_index,
  output logic [sfs_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfs_pkg::LEVEL_W-1:0]    cfg_start_level
);

  sfs_pkg::ctrl_cmd_t cmd;
  logic               cfg_we;

  // configuration writes are taken every cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer
  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath
  sfs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_freed_index  (in_freed_index),
    .cfg_we          (cfg_we),
    .cfg_start_level (cfg_start_level),
    .out_given_index (out_given_index),
    .out_status      (out_status)
  );

endmodule

@@ tb/sv/slot_allocator_free_stack_top_tb.sv @@
// self-checking testbench for slot_allocator_free_stack_top: directed and random requests
// an in-line allocator mirror predicts every reply; depends on sfs_pkg and the rtl top
`timescale 1ns / 1ps

module slot_allocator_free_stack_top_tb;

  localparam int CYCLE_LIMIT = 500000;

  // expected reply for one request item
  typedef struct {
    logic [sfs_pkg::SLOT_W-1:0] given;
    sfs_pkg::status_t           status;
  } slot_reply_t;

  // mirror of the allocator state plus the queue of replies still owed
  class allocator_mirror;
    logic [sfs_pkg::SLOT_W-1:0] free_stack [sfs_pkg::MAX_SLOTS];
    bit                         held [sfs_pkg::MAX_SLOTS];
    logic [sfs_pkg::CNT_W-1:0]  stack_count;
    logic [sfs_pkg::CNT_W-1:0]  high_water;
    logic [sfs_pkg::CNT_W-1:0]  capacity;
    slot_reply_t                awaited_replies[$];
    int                         mismatches;

    function new();
      stack_count = '0;
      high_water  = '0;
      mismatches  = 0;
      load_level('0);
    endfunction

    // level write reloads capacity only
    function void load_level(logic [sfs_pkg::LEVEL_W-1:0] lvl);
      int unsigned c;
      c = sfs_pkg::BASE_SLOTS << lvl;
      capacity = (c > sfs_pkg::MAX_SLOTS) ? sfs_pkg::CNT_W'(sfs_pkg::MAX_SLOTS)
                                          : sfs_pkg::CNT_W'(c);
    endfunction

    // apply one accepted request and queue its reply
    function void note_request(sfs_pkg::op_t op, logic [sfs_pkg::SLOT_W-1:0] idx);
      slot_reply_t r;
      r.given  = '0;
      r.status = sfs_pkg::ST_OK;
      case (op)
        sfs_pkg::OP_ALLOC: begin
          if (stack_count > 0) begin
            stack_count = stack_count - 1'b1;
            r.given = free_stack[stack_count];
            held[r.given] = 1'b1;
          end else if (high_water >= capacity) begin
            r.status = sfs_pkg::ST_NO_SLOT;
          end else begin
            r.given = high_water[sfs_pkg::SLOT_W-1:0];
            held[r.given] = 1'b1;
            high_water = high_water + 1'b1;
          end
        end
        sfs_pkg::OP_FREE: begin
          if (idx >= capacity || !held[idx] || stack_count >= sfs_pkg::MAX_SLOTS) begin
            r.status = sfs_pkg::ST_BAD_FREE;
          end else begin
            held[idx] = 1'b0;
            free_stack[stack_count] = idx;
            stack_count = stack_count + 1'b1;
          end
        end
        sfs_pkg::OP_GROW: begin
          if (capacity >= sfs_pkg::MAX_SLOTS) begin
            r.status = sfs_pkg::ST_CANNOT_GROW;
          end else if (capacity >= sfs_pkg::MAX_SLOTS / 2) begin
            capacity = sfs_pkg::CNT_W'(sfs_pkg::MAX_SLOTS);
          end else begin
            capacity = capacity << 1;
          end
        end
        default: ;
      endcase
      awaited_replies.push_back(r);
    endfunction

    // compare one accepted reply against the oldest awaited one
    function void check_reply(logic [sfs_pkg::SLOT_W-1:0] given,
                              logic [sfs_pkg::STATUS_W-1:0] status);
      slot_reply_t r;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply given_index=%0d status=%0d", $time, given, status);
        mismatches++;
        return;
      end
      r = awaited_replies.pop_front();
      if (given !== r.given) begin
        $display("%0t: given_index expected %0d actual %0d", $time, r.given, given);
        mismatches++;
      end
      if (status !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    // find some slot currently handed out, starting at a random point
    function bit pick_held(output logic [sfs_pkg::SLOT_W-1:0] idx);
      int unsigned start;
      int unsigned k;
      idx = '0;
      if (high_water == 0) return 1'b0;
      start = $urandom_range(0, int'(high_water) - 1);
      for (int i = 0; i < int'(high_water); i++) begin
        k = (start + i) % int'(high_water);
        if (held[k]) begin
          idx = k[sfs_pkg::SLOT_W-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [sfs_pkg::OP_W-1:0]     in_op = '0;
  logic [sfs_pkg::SLOT_W-1:0]   in_freed_index = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b1;
  logic [sfs_pkg::SLOT_W-1:0]   out_given_index;
  logic [sfs_pkg::STATUS_W-1:0] out_status;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sfs_pkg::LEVEL_W-1:0]  cfg_start_level = '0;

  allocator_mirror mirror = new();
  bit              idle_on = 1'b1;
  int              rx_hold_cycles = 0;
  int              cycle_count = 0;

  slot_allocator_free_stack_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_freed_index  (in_freed_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_given_index (out_given_index),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_start_level (cfg_start_level)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // reply side: check accepted items, random stalls and one long hold-off
  initial begin : reply_side
    int n;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        mirror.check_reply(out_given_index, out_status);
      end
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // offer one request item and hold it until accepted
  task automatic send_item(input sfs_pkg::op_t op, input logic [sfs_pkg::SLOT_W-1:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_freed_index <= idx;
    do @(posedge clk); while (!in_ready);
    mirror.note_request(op, idx);
  endtask

  // level write once every reply is back
  task automatic write_level(input logic [sfs_pkg::LEVEL_W-1:0] lvl);
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_start_level <= lvl;
    do @(posedge clk); while (!cfg_ready);
    mirror.load_level(lvl);
    cfg_valid <= 1'b0;
  endtask

  // random mix: allocs, frees of held slots, bad frees, grows, unused op
  task automatic run_mix(input int n_items, input int alloc_pct, input int free_pct);
    int                         r;
    logic [sfs_pkg::SLOT_W-1:0] idx;
    logic [sfs_pkg::SLOT_W-1:0] held_idx;
    for (int i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 99);
      idx = sfs_pkg::SLOT_W'($urandom);
      if (r < alloc_pct) begin
        send_item(sfs_pkg::OP_ALLOC, idx);
      end else if (r < alloc_pct + free_pct) begin
        if (mirror.pick_held(held_idx)) idx = held_idx;
        send_item(sfs_pkg::OP_FREE, idx);
      end else if (r < alloc_pct + free_pct + 10) begin
        if (r[0]) idx = sfs_pkg::SLOT_W'($urandom_range(0, int'(mirror.capacity) - 1));
        send_item(sfs_pkg::OP_FREE, idx);
      end else if (r < alloc_pct + free_pct + 15) begin
        send_item(sfs_pkg::OP_GROW, idx);
      end else begin
        send_item(sfs_pkg::OP_NOP, idx);
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_level(3'd0);

    // directed: stack reuse, bad frees, unused op, grow
    send_item(sfs_pkg::OP_ALLOC, '0);
    send_item(sfs_pkg::OP_ALLOC, '1);
    send_item(sfs_pkg::OP_FREE, 12'd0);
    send_item(sfs_pkg::OP_FREE, 12'd0);
    send_item(sfs_pkg::OP_ALLOC, '0);
    send_item(sfs_pkg::OP_FREE, 12'd4095);
    send_item(sfs_pkg::OP_FREE, 12'd31);
    send_item(sfs_pkg::OP_NOP, 12'd4095);
    send_item(sfs_pkg::OP_GROW, '0);
    send_item(sfs_pkg::OP_FREE, 12'd1);
    send_item(sfs_pkg::OP_FREE, 12'd0);
    send_item(sfs_pkg::OP_ALLOC, '0);
    send_item(sfs_pkg::OP_ALLOC, '0);
    send_item(sfs_pkg::OP_ALLOC, '1);

    // directed: grow at the largest capacity, free of a slot never handed out
    write_level(3'd7);
    send_item(sfs_pkg::OP_GROW, '0);
    send_item(sfs_pkg::OP_FREE, 12'd4095);
    send_item(sfs_pkg::OP_ALLOC, '0);

    // alloc-heavy at full capacity pushes the high-water mark up
    run_mix(350, 60, 25);

    // reload below the high-water mark: no slot until grown, bad frees above
    write_level(3'd0);
    run_mix(350, 45, 30);

    // long receiver hold-off while requests keep coming
    write_level(3'd3);
    run_mix(100, 45, 35);
    rx_hold_cycles = 300;
    run_mix(200, 45, 35);

    write_level(3'd5);
    run_mix(300, 45, 35);

    // free-heavy
    write_level(3'd1);
    run_mix(300, 30, 50);

    // last part runs without idling
    write_level(3'd6);
    idle_on = 1'b0;
    run_mix(330, 45, 35);

    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
